// File: design/ccp_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// ccp_pkg
// Beat types, result codes, sideband records and a shared helper for the
// friction cone projection pipeline.
// ============================================================================
package ccp_pkg;

  // Result classification codes.
  localparam logic [1:0] CASE_INSIDE = 2'd0;
  localparam logic [1:0] CASE_ZERO   = 2'd1;
  localparam logic [1:0] CASE_PROJ   = 2'd2;
  localparam logic [1:0] CASE_ZMU    = 2'd3;

  // One input beat.
  typedef struct packed {
    logic               func;
    logic signed [31:0] in_tangent_x;
    logic signed [31:0] in_tangent_y;
    logic signed [31:0] in_normal;
    logic        [15:0] friction;
  } in_beat_t;

  // One result beat.
  typedef struct packed {
    logic signed [31:0] out_tangent_x;
    logic signed [31:0] out_tangent_y;
    logic signed [31:0] out_normal;
    logic        [1:0]  case_taken;
    logic               saturated;
  } out_beat_t;

  // Sideband carried through the square root.
  typedef struct packed {
    logic               func;
    logic               zmu;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] n;
    logic        [15:0] a;
    logic        [15:0] b;
  } side1_t;

  // Sideband carried through the normal divider.
  typedef struct packed {
    logic               func;
    logic               zmu;
    logic               in_cone;
    logic               polar;
    logic               tnz;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] n;
    logic        [15:0] a;
    logic        [47:0] bt;
  } side2_t;

  // Sideband carried through the tangent dividers.
  typedef struct packed {
    logic               func;
    logic               zmu;
    logic               in_cone;
    logic               zero;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] n;
    logic        [33:0] pn;
  } side3_t;

  // Clamp a sign and magnitude into a 32-bit two's-complement value.
  // The top bit of the result is the saturation flag.
  function automatic logic [32:0] sat_pack(input logic neg, input logic [33:0] mag);
    logic [33:0] lim;
    logic [31:0] val;
    logic        sat;
    lim = neg ? 34'h080000000 : 34'h07FFFFFFF;
    sat = mag > lim;
    val = sat ? lim[31:0] : mag[31:0];
    if (neg) begin
      val = -val;
    end
    return {sat, val};
  endfunction

endpackage

// File: design/ccp_isqrt.sv
`timescale 1ns / 1ps
// ============================================================================
// ccp_isqrt
// Pipelined floor square root of a 64-bit value, one result bit per stage.
// ============================================================================
module ccp_isqrt #(
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [63:0]   in_val,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [31:0]   out_root,
  output logic [SW-1:0] out_side
);

  localparam int STEPS = 32;

  logic          valid_r [STEPS];
  logic [32:0]   rem_r   [STEPS];
  logic [31:0]   root_r  [STEPS];
  logic [63:0]   val_r   [STEPS];
  logic [SW-1:0] side_r  [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [32:0]   rem_c;
    logic [31:0]   root_c;
    logic [63:0]   val_c;
    logic [SW-1:0] side_c;
    logic          valid_c;
    logic [34:0]   cur;
    logic [34:0]   trial;
    logic          fits;

    // Stage inputs come from the port on the first step.
    if (k == 0) begin : g_first
      assign rem_c   = '0;
      assign root_c  = '0;
      assign val_c   = in_val;
      assign side_c  = in_side;
      assign valid_c = in_valid;
    end else begin : g_next
      assign rem_c   = rem_r[k-1];
      assign root_c  = root_r[k-1];
      assign val_c   = val_r[k-1];
      assign side_c  = side_r[k-1];
      assign valid_c = valid_r[k-1];
    end

    // Bring down the next bit pair and try the trial subtrahend.
    assign cur   = {rem_c, val_c[63:62]};
    assign trial = {1'b0, root_c, 2'b01};
    assign fits  = cur >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (en) begin
        valid_r[k] <= valid_c;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= fits ? 33'(cur - trial) : cur[32:0];
        root_r[k] <= {root_c[30:0], fits};
        val_r[k]  <= {val_c[61:0], 2'b00};
        side_r[k] <= side_c;
      end
    end
  end

  assign out_valid = valid_r[STEPS-1];
  assign out_root  = root_r[STEPS-1];
  assign out_side  = side_r[STEPS-1];

endmodule

// File: design/ccp_div.sv
`timescale 1ns / 1ps
// ============================================================================
// ccp_div
// Pipelined restoring divider, one quotient bit per stage. The caller
// guarantees that the quotient fits in QW bits.
// ============================================================================
module ccp_div #(
  parameter int NW = 65,
  parameter int DW = 33,
  parameter int QW = 34,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QW-1:0] out_quo,
  output logic [SW-1:0] out_side
);

  logic [NW-1:0] top;

  logic          valid_r [QW];
  logic [DW-1:0] rem_r   [QW];
  logic [DW-1:0] den_r   [QW];
  logic [QW-1:0] quo_r   [QW];
  logic [QW-1:0] low_r   [QW];
  logic [SW-1:0] side_r  [QW];

  // The upper numerator bits are already below the divisor.
  assign top = in_num >> QW;

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DW-1:0] rem_c;
    logic [DW-1:0] den_c;
    logic [QW-1:0] quo_c;
    logic [QW-1:0] low_c;
    logic [SW-1:0] side_c;
    logic          valid_c;
    logic [DW:0]   cur;
    logic          fits;

    if (k == 0) begin : g_first
      assign rem_c   = top[DW-1:0];
      assign den_c   = in_den;
      assign quo_c   = '0;
      assign low_c   = in_num[QW-1:0];
      assign side_c  = in_side;
      assign valid_c = in_valid;
    end else begin : g_next
      assign rem_c   = rem_r[k-1];
      assign den_c   = den_r[k-1];
      assign quo_c   = quo_r[k-1];
      assign low_c   = low_r[k-1];
      assign side_c  = side_r[k-1];
      assign valid_c = valid_r[k-1];
    end

    // Shift in one numerator bit and subtract when the divisor fits.
    assign cur  = {rem_c, low_c[QW-1]};
    assign fits = cur >= {1'b0, den_c};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (en) begin
        valid_r[k] <= valid_c;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= fits ? DW'(cur - {1'b0, den_c}) : cur[DW-1:0];
        den_r[k]  <= den_c;
        quo_r[k]  <= {quo_c[QW-2:0], fits};
        low_r[k]  <= {low_c[QW-2:0], 1'b0};
        side_r[k] <= side_c;
      end
    end
  end

  assign out_valid = valid_r[QW-1];
  assign out_quo   = quo_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule

// File: design/coulomb_cone_projection_top.sv
`timescale 1ns / 1ps
// Throughput: one beat per cycle while the output is not stalled; the square
// root and the three dividers are unrolled into one bit per pipeline stage,
// so nothing iterates in place.
// A stalled output freezes the whole pipeline in place, nothing is lost.
// Reset (rst_n low, synchronous) clears every stage valid bit; data
// registers are not reset.
// ============================================================================
// coulomb_cone_projection_top
// Projects a contact vector per unstalled cycle onto a Coulomb friction cone.
// ============================================================================
module coulomb_cone_projection_top #(
  parameter int MU_FRAC_BITS = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ccp_pkg::in_beat_t   in_beat,
  output logic                out_valid,
  input  logic                out_stall,
  output ccp_pkg::out_beat_t  out_beat
);

  localparam logic [15:0] MU_ONE = 16'(1) << MU_FRAC_BITS;

  logic en;

  // Stage 0: capture, slope selection and magnitudes.
  logic            s0_valid_r;
  ccp_pkg::side1_t s0_side_r, s0_side_nxt;
  logic [31:0]     s0_mx_r, s0_my_r;

  // Stages 1 and 2: squares and their sum.
  logic            s1_valid_r, s2_valid_r;
  ccp_pkg::side1_t s1_side_r, s2_side_r;
  logic [63:0]     s1_sqx_r, s1_sqy_r, s2_sum_r;

  // Square root outputs.
  logic            sq_valid;
  logic [31:0]     sq_root;
  ccp_pkg::side1_t sq_side;

  // Stages P1 to P3: cone tests and the normal numerator.
  logic               p1_valid_r, p2_valid_r, p3_valid_r;
  ccp_pkg::side1_t    p1_side_r, p2_side_r;
  logic [47:0]        p1_bt_r, p1_atn_r, p2_bt_r;
  logic signed [48:0] p1_an_r, p1_bn_r;
  logic [31:0]        p1_aa_r, p1_bb_r;
  logic               p1_tnz_r, p2_tnz_r, p2_inside_r;
  logic signed [49:0] p2_u_r;
  logic [32:0]        p2_dd_r, p3_dd_r;
  logic               p3_polar;
  logic [64:0]        p3_ub_r;
  ccp_pkg::side2_t    p3_side_r, p3_side_nxt;

  // Normal divider outputs.
  logic            da_valid;
  logic [33:0]     da_quo;
  ccp_pkg::side2_t da_side;

  // Stages M1 to M3: tangent numerators.
  logic            m1_valid_r, m2_valid_r, m3_valid_r;
  ccp_pkg::side3_t m1_side_r, m1_side_nxt, m2_side_r, m3_side_r;
  logic [49:0]     m1_ap_r;
  logic [31:0]     m1_mx_r, m1_my_r;
  logic [47:0]     m1_bt_r, m2_bt_r, m3_bt_r;
  logic [56:0]     m2_pxl_r, m2_pxh_r, m2_pyl_r, m2_pyh_r;
  logic [81:0]     m3_numx_r, m3_numy_r;

  // Tangent divider outputs.
  logic            dx_valid, dy_valid;
  logic [33:0]     dx_quo, dy_quo;
  ccp_pkg::side3_t dx_side;
  logic            dy_neg;

  // Output stage.
  logic               out_valid_r;
  ccp_pkg::out_beat_t out_beat_r, out_beat_nxt;
  logic [32:0]        pk_x, pk_y, pk_n;

  // The pipeline advances as one unless a finished beat is held.
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // Stage 0 logic.
  always_comb begin
    s0_side_nxt.func = in_beat.func;
    s0_side_nxt.zmu  = in_beat.friction == 16'd0;
    s0_side_nxt.tx   = in_beat.in_tangent_x;
    s0_side_nxt.ty   = in_beat.in_tangent_y;
    s0_side_nxt.n    = in_beat.in_normal;
    s0_side_nxt.a    = in_beat.func ? MU_ONE : in_beat.friction;
    s0_side_nxt.b    = in_beat.func ? in_beat.friction : MU_ONE;
  end

  // Valid bits of the local stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      p1_valid_r  <= 1'b0;
      p2_valid_r  <= 1'b0;
      p3_valid_r  <= 1'b0;
      m1_valid_r  <= 1'b0;
      m2_valid_r  <= 1'b0;
      m3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s0_valid_r  <= in_valid;
      s1_valid_r  <= s0_valid_r;
      s2_valid_r  <= s1_valid_r;
      p1_valid_r  <= sq_valid;
      p2_valid_r  <= p1_valid_r;
      p3_valid_r  <= p2_valid_r;
      m1_valid_r  <= da_valid;
      m2_valid_r  <= m1_valid_r;
      m3_valid_r  <= m2_valid_r;
      out_valid_r <= dx_valid && dy_valid;
    end
  end

  // Front stages: magnitudes, squares, sum.
  always_ff @(posedge clk) begin
    if (en) begin
      s0_side_r <= s0_side_nxt;
      s0_mx_r   <= in_beat.in_tangent_x[31] ? -in_beat.in_tangent_x : in_beat.in_tangent_x;
      s0_my_r   <= in_beat.in_tangent_y[31] ? -in_beat.in_tangent_y : in_beat.in_tangent_y;
      s1_side_r <= s0_side_r;
      s1_sqx_r  <= 64'(s0_mx_r) * 64'(s0_mx_r);
      s1_sqy_r  <= 64'(s0_my_r) * 64'(s0_my_r);
      s2_side_r <= s1_side_r;
      s2_sum_r  <= s1_sqx_r + s1_sqy_r;
    end
  end

  ccp_isqrt #(
    .SW($bits(ccp_pkg::side1_t))
  ) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (s2_valid_r),
    .in_val   (s2_sum_r),
    .in_side  (s2_side_r),
    .out_valid(sq_valid),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  // P3 classification of the polar cone and the divider record.
  assign p3_polar = p2_u_r[49] || (p2_u_r == '0);

  always_comb begin
    p3_side_nxt.func    = p2_side_r.func;
    p3_side_nxt.zmu     = p2_side_r.zmu;
    p3_side_nxt.in_cone = p2_inside_r;
    p3_side_nxt.polar   = p3_polar;
    p3_side_nxt.tnz     = p2_tnz_r;
    p3_side_nxt.tx      = p2_side_r.tx;
    p3_side_nxt.ty      = p2_side_r.ty;
    p3_side_nxt.n       = p2_side_r.n;
    p3_side_nxt.a       = p2_side_r.a;
    p3_side_nxt.bt      = p2_bt_r;
  end

  // Cone tests: slope products, inside test, polar numerator.
  always_ff @(posedge clk) begin
    if (en) begin
      p1_side_r   <= sq_side;
      p1_bt_r     <= 48'(sq_side.b) * 48'(sq_root);
      p1_atn_r    <= 48'(sq_side.a) * 48'(sq_root);
      p1_an_r     <= $signed({1'b0, sq_side.a}) * $signed(sq_side.n);
      p1_bn_r     <= $signed({1'b0, sq_side.b}) * $signed(sq_side.n);
      p1_aa_r     <= 32'(sq_side.a) * 32'(sq_side.a);
      p1_bb_r     <= 32'(sq_side.b) * 32'(sq_side.b);
      p1_tnz_r    <= sq_root == 32'd0;
      p2_side_r   <= p1_side_r;
      p2_bt_r     <= p1_bt_r;
      p2_tnz_r    <= p1_tnz_r;
      p2_inside_r <= !p1_side_r.n[31] && (p1_bt_r <= p1_an_r[47:0]);
      p2_u_r      <= $signed({2'b00, p1_atn_r}) + $signed({p1_bn_r[48], p1_bn_r});
      p2_dd_r     <= {1'b0, p1_aa_r} + {1'b0, p1_bb_r};
      p3_side_r   <= p3_side_nxt;
      p3_dd_r     <= p2_dd_r;
      p3_ub_r     <= p3_polar ? '0 : {16'd0, p2_u_r[48:0]} * {49'd0, p2_side_r.b};
    end
  end

  ccp_div #(
    .NW(65),
    .DW(33),
    .QW(34),
    .SW($bits(ccp_pkg::side2_t))
  ) u_div_normal (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (p3_valid_r),
    .in_num   (p3_ub_r),
    .in_den   (p3_dd_r),
    .in_side  (p3_side_r),
    .out_valid(da_valid),
    .out_quo  (da_quo),
    .out_side (da_side)
  );

  // M1 record: everything the tangent stages and the output need.
  always_comb begin
    m1_side_nxt.func    = da_side.func;
    m1_side_nxt.zmu     = da_side.zmu;
    m1_side_nxt.in_cone = da_side.in_cone;
    m1_side_nxt.zero    = da_side.polar || da_side.tnz || (da_quo == '0);
    m1_side_nxt.tx      = da_side.tx;
    m1_side_nxt.ty      = da_side.ty;
    m1_side_nxt.n       = da_side.n;
    m1_side_nxt.pn      = da_quo;
  end

  // Tangent numerators a*pn*|t|, the wide product split in two halves.
  always_ff @(posedge clk) begin
    if (en) begin
      m1_side_r <= m1_side_nxt;
      m1_ap_r   <= 50'(da_side.a) * 50'(da_quo);
      m1_bt_r   <= da_side.bt;
      m1_mx_r   <= da_side.tx[31] ? -da_side.tx : da_side.tx;
      m1_my_r   <= da_side.ty[31] ? -da_side.ty : da_side.ty;
      m2_side_r <= m1_side_r;
      m2_bt_r   <= m1_bt_r;
      m2_pxl_r  <= 57'(m1_ap_r[24:0]) * 57'(m1_mx_r);
      m2_pxh_r  <= 57'(m1_ap_r[49:25]) * 57'(m1_mx_r);
      m2_pyl_r  <= 57'(m1_ap_r[24:0]) * 57'(m1_my_r);
      m2_pyh_r  <= 57'(m1_ap_r[49:25]) * 57'(m1_my_r);
      m3_side_r <= m2_side_r;
      m3_bt_r   <= m2_bt_r;
      m3_numx_r <= 82'(m2_pxl_r) + (82'(m2_pxh_r) << 25);
      m3_numy_r <= 82'(m2_pyl_r) + (82'(m2_pyh_r) << 25);
    end
  end

  ccp_div #(
    .NW(82),
    .DW(48),
    .QW(34),
    .SW($bits(ccp_pkg::side3_t))
  ) u_div_tx (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (m3_valid_r),
    .in_num   (m3_numx_r),
    .in_den   (m3_bt_r),
    .in_side  (m3_side_r),
    .out_valid(dx_valid),
    .out_quo  (dx_quo),
    .out_side (dx_side)
  );

  ccp_div #(
    .NW(82),
    .DW(48),
    .QW(34),
    .SW(1)
  ) u_div_ty (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (m3_valid_r),
    .in_num   (m3_numy_r),
    .in_den   (m3_bt_r),
    .in_side  (m3_side_r.ty[31]),
    .out_valid(dy_valid),
    .out_quo  (dy_quo),
    .out_side (dy_neg)
  );

  // Clamp the projected components.
  assign pk_x = ccp_pkg::sat_pack(dx_side.tx[31], dx_quo);
  assign pk_y = ccp_pkg::sat_pack(dy_neg, dy_quo);
  assign pk_n = ccp_pkg::sat_pack(1'b0, dx_side.pn);

  // Result selection.
  always_comb begin
    out_beat_nxt = '0;
    if (dx_side.zmu) begin
      out_beat_nxt.out_tangent_x = dx_side.func ? dx_side.tx : 32'sd0;
      out_beat_nxt.out_tangent_y = dx_side.func ? dx_side.ty : 32'sd0;
      out_beat_nxt.out_normal    = dx_side.n[31] ? 32'sd0 : dx_side.n;
      out_beat_nxt.case_taken    = ccp_pkg::CASE_ZMU;
    end else if (dx_side.in_cone) begin
      out_beat_nxt.out_tangent_x = dx_side.tx;
      out_beat_nxt.out_tangent_y = dx_side.ty;
      out_beat_nxt.out_normal    = dx_side.n;
      out_beat_nxt.case_taken    = ccp_pkg::CASE_INSIDE;
    end else if (dx_side.zero) begin
      out_beat_nxt.case_taken    = ccp_pkg::CASE_ZERO;
    end else begin
      out_beat_nxt.out_tangent_x = pk_x[31:0];
      out_beat_nxt.out_tangent_y = pk_y[31:0];
      out_beat_nxt.out_normal    = pk_n[31:0];
      out_beat_nxt.case_taken    = ccp_pkg::CASE_PROJ;
      out_beat_nxt.saturated     = pk_x[32] || pk_y[32] || pk_n[32];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_beat_r <= out_beat_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  // Only a projected beat can report saturation.
  a_sat_only_proj: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_beat.case_taken != ccp_pkg::CASE_PROJ) |-> !out_beat.saturated)
    else $error("saturation flagged on a beat that was not projected");

  // A zeroed beat carries zero in all three components.
  a_zero_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_beat.case_taken == ccp_pkg::CASE_ZERO) |->
      (out_beat.out_tangent_x == 0 && out_beat.out_tangent_y == 0 &&
       out_beat.out_normal == 0))
    else $error("zeroed beat has a nonzero component");

  // The frictionless case never returns a negative normal.
  a_zmu_normal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_beat.case_taken == ccp_pkg::CASE_ZMU) |-> !out_beat.out_normal[31])
    else $error("frictionless beat has a negative normal");

  // A held result freezes the pipeline interior.
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> ($stable(s2_valid_r) && $stable(m3_valid_r)))
    else $error("pipeline moved while the output was held");

  // Both tangent dividers stay in lockstep.
  a_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    dx_valid == dy_valid)
    else $error("tangent dividers out of step");

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// Friction cone projection testbench
// Sends contact vectors through the projection pipeline and compares every
// result beat with a behavioral predictor. A short table of directed vectors
// comes first, then random vectors shaped to hit each projection case.
// ============================================================================
module tb;

  localparam int MU_ONE_SHIFT = 12;
  localparam int LATENCY      = 110;
  localparam int N_RANDOM     = 800;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  ccp_pkg::in_beat_t  in_beat;
  logic               out_valid;
  logic               out_stall;
  ccp_pkg::out_beat_t out_beat;

  coulomb_cone_projection_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_beat(in_beat),
    .out_valid(out_valid), .out_stall(out_stall), .out_beat(out_beat)
  );

  // Clock generation.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Directed stimulus row; has_exp marks rows whose result is typed in.
  typedef struct {
    ccp_pkg::in_beat_t  beat;
    logic               has_exp;
    ccp_pkg::out_beat_t exp;
  } dir_row_t;

  ccp_pkg::out_beat_t proj_queue[$];
  int                 mismatches;
  logic               quiet_out;

  // Integer square root, floor.
  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] bitv;
    r = 64'd0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v = v - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  // Clamp sign and magnitude into 32 bits, flagging saturation.
  function automatic logic [31:0] clamp32(input logic neg, input logic [127:0] mag,
                                          inout logic sat);
    if (!neg) begin
      if (mag > 128'h7FFFFFFF) begin
        mag = 128'h7FFFFFFF;
        sat = 1'b1;
      end
      return mag[31:0];
    end
    if (mag > 128'h80000000) begin
      mag = 128'h80000000;
      sat = 1'b1;
    end
    return 32'(-mag[31:0]);
  endfunction

  // Predicts the projected contact vector for one input beat.
  function automatic ccp_pkg::out_beat_t project_contact(input ccp_pkg::in_beat_t ib);
    ccp_pkg::out_beat_t  r;
    logic signed [63:0]  tx, ty, n;
    logic [63:0]         mx, my, a, b, tn;
    logic signed [127:0] u;
    logic [127:0]        pn, qx, qy;
    logic                sat;
    tx = 64'($signed(ib.in_tangent_x));
    ty = 64'($signed(ib.in_tangent_y));
    n  = 64'($signed(ib.in_normal));
    r = '0;
    sat = 1'b0;
    if (ib.friction == 16'd0) begin
      if (ib.func) begin
        r.out_tangent_x = ib.in_tangent_x;
        r.out_tangent_y = ib.in_tangent_y;
      end
      r.out_normal = (n > 0) ? ib.in_normal : '0;
      r.case_taken = ccp_pkg::CASE_ZMU;
      return r;
    end
    if (ib.func) begin
      a = 64'd1 << MU_ONE_SHIFT;
      b = 64'(ib.friction);
    end else begin
      a = 64'(ib.friction);
      b = 64'd1 << MU_ONE_SHIFT;
    end
    mx = (tx < 0) ? -tx : tx;
    my = (ty < 0) ? -ty : ty;
    tn = floor_sqrt(mx * mx + my * my);
    if (n >= 0 && b * tn <= a * n) begin
      r.out_tangent_x = ib.in_tangent_x;
      r.out_tangent_y = ib.in_tangent_y;
      r.out_normal = ib.in_normal;
      r.case_taken = ccp_pkg::CASE_INSIDE;
      return r;
    end
    u = $signed({64'd0, a * tn}) + $signed({64'd0, b}) * $signed({{64{n[63]}}, n});
    if (u <= 0) begin
      r.case_taken = ccp_pkg::CASE_ZERO;
      return r;
    end
    pn = (128'(u) * b) / (a * a + b * b);
    if (pn == 0 || tn == 0) begin
      r.case_taken = ccp_pkg::CASE_ZERO;
      return r;
    end
    qx = (a * pn * mx) / (b * tn);
    qy = (a * pn * my) / (b * tn);
    r.out_tangent_x = clamp32(tx < 0, qx, sat);
    r.out_tangent_y = clamp32(ty < 0, qy, sat);
    r.out_normal = clamp32(1'b0, pn, sat);
    r.case_taken = ccp_pkg::CASE_PROJ;
    r.saturated = sat;
    return r;
  endfunction

  function automatic ccp_pkg::in_beat_t mk(input logic f, input logic [31:0] x,
                                           input logic [31:0] y, input logic [31:0] n,
                                           input logic [15:0] mu);
    ccp_pkg::in_beat_t b;
    b.func = f;
    b.in_tangent_x = x;
    b.in_tangent_y = y;
    b.in_normal = n;
    b.friction = mu;
    return b;
  endfunction

  function automatic ccp_pkg::out_beat_t ob(input logic [31:0] x, input logic [31:0] y,
                                            input logic [31:0] n, input logic [1:0] c);
    ccp_pkg::out_beat_t o;
    o.out_tangent_x = x;
    o.out_tangent_y = y;
    o.out_normal = n;
    o.case_taken = c;
    o.saturated = 1'b0;
    return o;
  endfunction

  // Random 32-bit value, biased toward small magnitudes half the time.
  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 32'h0FFFFF)) - 32'sh80000);
      2: return 32'($signed($urandom_range(0, 32'h3FFFFFF)) - 32'sh2000000);
      default: return $urandom_range(0, 1) ? 32'h7FFFFFFF - $urandom_range(0, 255)
                                           : 32'h80000000 + $urandom_range(0, 255);
    endcase
  endfunction

  // Drive one beat and wait until it is accepted; random idle bursts before it.
  task automatic send_beat(input ccp_pkg::in_beat_t b, input logic gaps);
    int idle;
    if (gaps && $urandom_range(0, 3) == 0) begin
      idle = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat <= b;
    proj_queue.insert(proj_queue.size(), project_contact(b));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Output side: random stall bursts, checks on each accepted result beat.
  initial begin : result_side
    int burst;
    out_stall = 1'b0;
    burst = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (proj_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result beat %p", out_beat);
        end else begin
          ccp_pkg::out_beat_t e;
          e = proj_queue.pop_front();
          if (out_beat !== e) begin
            mismatches++;
            if (mismatches <= 10) $display("Mismatch: expected %p, got %p", e, out_beat);
          end
        end
      end
      if (burst > 0) begin
        burst--;
        out_stall <= 1'b1;
      end else if (!quiet_out && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(0, 7);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Main stimulus.
  initial begin : stim
    dir_row_t          rows[$];
    ccp_pkg::in_beat_t b;
    mismatches = 0;
    quiet_out = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_beat = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: zero mu, inside, polar, projection, extremes.
    rows = '{
      '{mk(1'b0, 5, -7, 9, 16'h0000), 1'b1, ob(0, 0, 9, ccp_pkg::CASE_ZMU)},
      '{mk(1'b1, 5, -7, -9, 16'h0000), 1'b1, ob(5, -7, 0, ccp_pkg::CASE_ZMU)},
      '{mk(1'b1, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h0000), 1'b1,
        ob(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, ccp_pkg::CASE_ZMU)},
      '{mk(1'b0, 0, 0, 0, 16'h1000), 1'b1, ob(0, 0, 0, ccp_pkg::CASE_INSIDE)},
      '{mk(1'b0, 3, 4, 100, 16'h1000), 1'b1, ob(3, 4, 100, ccp_pkg::CASE_INSIDE)},
      '{mk(1'b1, 3, 4, 100, 16'h1000), 1'b1, ob(3, 4, 100, ccp_pkg::CASE_INSIDE)},
      '{mk(1'b0, 3, 4, -100, 16'h1000), 1'b1, ob(0, 0, 0, ccp_pkg::CASE_ZERO)},
      '{mk(1'b0, 0, 0, -1, 16'h1000), 1'b1, ob(0, 0, 0, ccp_pkg::CASE_ZERO)},
      '{mk(1'b0, 1, 0, 0, 16'h1000), 1'b1, ob(0, 0, 0, ccp_pkg::CASE_ZERO)},
      '{mk(1'b0, 32'h00100000, 0, 0, 16'h1000), 1'b0, '0},
      '{mk(1'b1, 32'h00100000, 32'hFFF00000, 32'h00010000, 16'h0800), 1'b0, '0},
      '{mk(1'b0, 32'h80000000, 32'h80000000, 32'h80000000, 16'hFFFF), 1'b0, '0},
      '{mk(1'b0, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 16'hFFFF), 1'b0, '0},
      '{mk(1'b1, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h0001), 1'b0, '0},
      '{mk(1'b0, 32'h7FFFFFFF, 32'h80000000, 32'h00000000, 16'hFFFF), 1'b0, '0},
      '{mk(1'b1, 32'h80000000, 0, 32'h40000000, 16'hFFFF), 1'b0, '0},
      '{mk(1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h7FFFFFFF, 16'h0001), 1'b0, '0},
      '{mk(1'b1, 32'h12345678, 32'hEDCBA987, 32'hFFFF0000, 16'h1800), 1'b0, '0}
    };
    foreach (rows[i]) begin
      b = rows[i].beat;
      send_beat(b, 1'b1);
      if (rows[i].has_exp) begin
        proj_queue[proj_queue.size() - 1] = rows[i].exp;
      end
    end
    in_valid <= 1'b0;

    // Let the pipeline drain completely before the random part.
    while (proj_queue.size() != 0) @(posedge clk);

    // Random part; the tail runs with no idling on either side.
    for (int i = 0; i < N_RANDOM; i++) begin
      logic [15:0] mu;
      if (i == N_RANDOM - 100) quiet_out = 1'b1;
      case ($urandom_range(0, 9))
        0: mu = 16'd0;
        1: mu = 16'hFFFF - 16'($urandom_range(0, 3));
        2: mu = 16'($urandom_range(1, 4));
        default: mu = 16'($urandom_range(1, 16'h3000));
      endcase
      b = mk(1'($urandom_range(0, 1)), rand_val(), rand_val(), rand_val(), mu);
      send_beat(b, i < N_RANDOM - 100);
    end
    in_valid <= 1'b0;

    while (proj_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (mismatches == 0 && proj_queue.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin : watchdog
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// File: files.f
design/ccp_pkg.sv
design/ccp_isqrt.sv
design/ccp_div.sv
design/coulomb_cone_projection_top.sv
test/tb.sv
